/* hw/rtl/ssc_pkg.sv */
// Shared types, constants and the digit decoder for the seven-segment chain driver
package ssc_pkg;

    // Display chain geometry
    localparam int GROUPS           = 3;
    localparam int SUBPOSITIONS     = 3;
    localparam int BITS_PER_DISPLAY = 8;
    localparam int NUM_DISPLAYS     = GROUPS * SUBPOSITIONS;
    localparam int TOTAL_BITS       = NUM_DISPLAYS * BITS_PER_DISPLAY;

    // Derived widths
    localparam int DISP_W = (NUM_DISPLAYS > 1) ? $clog2(NUM_DISPLAYS) : 1;
    localparam int CNT_W  = $clog2(TOTAL_BITS + 1);
    localparam int BIT_W  = $clog2(BITS_PER_DISPLAY);
    localparam int IDX_W  = 6;  // holds group * SUBPOSITIONS + subposition for this geometry (at most 12)

    // Action codes
    localparam logic [1:0] ACT_SET   = 2'd0;
    localparam logic [1:0] ACT_BLANK = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;
    localparam logic [1:0] ACT_TICK  = 2'd3;

    typedef logic [BITS_PER_DISPLAY-1:0] seg_t;
    typedef logic [DISP_W-1:0]           disp_idx_t;
    typedef logic [CNT_W-1:0]            cnt_t;

    // Input word
    typedef struct packed {
        logic [1:0] action;
        logic [1:0] group;
        logic [1:0] subposition;
        logic [3:0] digit;
        logic       dot;
    } item_t;

    // Result word
    typedef struct packed {
        logic serial_data;
        logic shift_pulse;
        logic latch_pulse;
        logic busy_res;
        logic refused;
    } result_t;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_SHIFT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // capture a result word
        logic store_we;    // write a segment byte
        logic store_blank; // written byte is zero
        logic cnt_clr;
        logic cnt_inc;
        logic shift_out;
        logic latch_out;
        logic refuse;
        logic busy;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic count_done;  // every bit of the chain has been sent
        logic addr_ok;     // group and subposition are in range
    } status_t;

    // Digit to segment pattern; digits above nine are dark
    function automatic seg_t seg_pattern(input logic [3:0] digit);
        seg_t pat;
        unique case (digit)
            4'd0:    pat = 8'hFC;
            4'd1:    pat = 8'h60;
            4'd2:    pat = 8'hDA;
            4'd3:    pat = 8'hF2;
            4'd4:    pat = 8'h66;
            4'd5:    pat = 8'hB6;
            4'd6:    pat = 8'hBE;
            4'd7:    pat = 8'hE0;
            4'd8:    pat = 8'hFE;
            4'd9:    pat = 8'hE6;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

endpackage

/* hw/rtl/ssc_ctrl.sv */
// Controller state machine: decodes each accepted word into datapath commands
module ssc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [1:0]        action,
    input  ssc_pkg::status_t  status,
    output ssc_pkg::cmd_t     cmd
);

    ssc_pkg::state_t state_reg;
    ssc_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ssc_pkg::ST_IDLE:
            begin
                if (accept && action == ssc_pkg::ACT_FLUSH)
                begin
                    state_next = ssc_pkg::ST_SHIFT;
                end
            end
            ssc_pkg::ST_SHIFT:
            begin
                if (accept && action == ssc_pkg::ACT_TICK && status.count_done)
                begin
                    state_next = ssc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssc_pkg::ST_IDLE;
            end
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd      = '0;
        cmd.load = accept;
        cmd.busy = (state_next == ssc_pkg::ST_SHIFT);
        unique case (state_reg)
            ssc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (action == ssc_pkg::ACT_FLUSH)
                    begin
                        cmd.cnt_clr = 1'b1;
                    end
                    else if (action != ssc_pkg::ACT_TICK && status.addr_ok)
                    begin
                        cmd.store_we    = 1'b1;
                        cmd.store_blank = (action == ssc_pkg::ACT_BLANK);
                    end
                end
            end
            ssc_pkg::ST_SHIFT:
            begin
                if (accept)
                begin
                    if (action != ssc_pkg::ACT_TICK)
                    begin
                        cmd.refuse = 1'b1;
                    end
                    else if (status.count_done)
                    begin
                        cmd.latch_out = 1'b1;
                        cmd.cnt_clr   = 1'b1;
                    end
                    else
                    begin
                        cmd.shift_out = 1'b1;
                        cmd.cnt_inc   = 1'b1;
                    end
                end
            end
            default:
            begin
                cmd.load = accept;
            end
        endcase
    end

endmodule

/* hw/rtl/ssc_datapath.sv */
// Datapath: segment store, bit counter, serial bit select and result register
module ssc_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  ssc_pkg::item_t    item,
    input  ssc_pkg::cmd_t     cmd,
    output ssc_pkg::status_t  status,
    output ssc_pkg::result_t  result
);

    ssc_pkg::seg_t     store_reg [ssc_pkg::NUM_DISPLAYS];
    ssc_pkg::cnt_t     cnt_reg;
    ssc_pkg::cnt_t     cnt_next;
    ssc_pkg::result_t  result_reg;
    ssc_pkg::result_t  result_next;

    logic [ssc_pkg::IDX_W-1:0] wr_idx_full;
    ssc_pkg::disp_idx_t        wr_idx;
    ssc_pkg::seg_t             wr_data;
    ssc_pkg::cnt_t             disp_from_cnt;
    ssc_pkg::cnt_t             rd_idx_full;
    ssc_pkg::disp_idx_t        rd_idx;
    logic [ssc_pkg::BIT_W-1:0] rd_bit;
    logic                      ser_bit;

    // Address and data for set or blank
    assign wr_idx_full = ssc_pkg::IDX_W'(item.group) * ssc_pkg::IDX_W'(ssc_pkg::SUBPOSITIONS)
                       + ssc_pkg::IDX_W'(item.subposition);
    assign wr_idx      = ssc_pkg::DISP_W'(wr_idx_full);
    assign wr_data     = cmd.store_blank ? '0
                       : (ssc_pkg::seg_pattern(item.digit)
                          | ssc_pkg::seg_t'(item.dot));

    assign status.addr_ok    = (32'(item.group) < ssc_pkg::GROUPS)
                            && (32'(item.subposition) < ssc_pkg::SUBPOSITIONS);
    assign status.count_done = (cnt_reg == ssc_pkg::CNT_W'(ssc_pkg::TOTAL_BITS));

    // Last display first, each byte LSB first
    assign disp_from_cnt = cnt_reg >> ssc_pkg::BIT_W;
    assign rd_idx_full   = ssc_pkg::CNT_W'(ssc_pkg::NUM_DISPLAYS - 1) - disp_from_cnt;
    assign rd_idx        = ssc_pkg::DISP_W'(rd_idx_full);
    assign rd_bit        = cnt_reg[ssc_pkg::BIT_W-1:0];
    assign ser_bit       = status.count_done ? 1'b0 : store_reg[rd_idx][rd_bit];

    // Segment store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ssc_pkg::NUM_DISPLAYS; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (cmd.store_we)
        begin
            store_reg[wr_idx] <= wr_data;
        end
    end

    // Bit counter
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + ssc_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Result word
    always_comb
    begin
        result_next             = '0;
        result_next.serial_data = cmd.shift_out & ser_bit;
        result_next.shift_pulse = cmd.shift_out;
        result_next.latch_pulse = cmd.latch_out;
        result_next.busy_res    = cmd.busy;
        result_next.refused     = cmd.refuse;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

/* hw/rtl/seven_segment_chain_driver.sv */
// Top level of the seven-segment daisy-chain driver
//
//   channel   valid          stall          word
//   input     item_valid     item_stall     item   (ssc_pkg::item_t)
//   output    result_valid   result_stall   result (ssc_pkg::result_t)
//
// One word is accepted per cycle unless the input is stalled; its result appears in the output register
// on the next cycle. The output register is the only buffer, so the input
// stalls only while a result waits and the output is stalled.
// Reset clears the segment store, the bit counter and the state machine.
// A full shift-out is NUM_DISPLAYS * 8 shift ticks plus one latch tick.
module seven_segment_chain_driver (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  ssc_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_stall,
    output ssc_pkg::result_t  result
);

    logic              accept;
    logic              result_valid_reg;
    logic              result_valid_next;
    ssc_pkg::cmd_t     cmd;
    ssc_pkg::status_t  status;

    // Handshake
    assign item_stall = result_valid_reg & result_stall;
    assign accept     = item_valid & ~item_stall;

    assign result_valid_next = accept | (result_valid_reg & result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

    ssc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .action (item.action),
        .status (status),
        .cmd    (cmd)
    );

    ssc_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

`ifndef SYNTH
    // A latch pulse ends the shift-out
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.latch_pulse |-> !result.busy_res)
        else $error("latch pulse with busy still set");

    // Shift pulses only happen inside a shift-out
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.shift_pulse |-> result.busy_res && !result.refused)
        else $error("shift pulse outside a shift-out");

    // An accepted flush while idle starts a shift-out
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.action == ssc_pkg::ACT_FLUSH |=> result.busy_res)
        else $error("flush did not leave the driver busy");

    // Data line is quiet unless shifting
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.serial_data |-> result.shift_pulse)
        else $error("serial data without shift pulse");
`endif

endmodule

/* tb/sv/ssc_chain_checker.sv */
// Checker for the seven-segment chain driver: predicts each result word and compares it
module ssc_chain_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_stall,
    input  ssc_pkg::item_t   item,
    input  logic             result_valid,
    input  logic             result_stall,
    input  ssc_pkg::result_t result,
    output int               fail_count,
    output int               results_due
);

    // Segment patterns for digits 0..15, digit 0 in the low byte; above nine is dark
    localparam logic [16*8-1:0] DIGIT_SEGS = {
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE6, 8'hFE,
        8'hE0, 8'hBE, 8'hB6, 8'h66, 8'hF2, 8'hDA, 8'h60, 8'hFC
    };

    // Shadow of the block state
    ssc_pkg::seg_t    disp_bytes [ssc_pkg::NUM_DISPLAYS];
    int               bits_sent    = 0;
    logic             shift_active = 1'b0;

    ssc_pkg::result_t chain_results_due [$];
    int               mismatches = 0;

    // Advance the shadow by one accepted word and return the word it must produce
    function automatic ssc_pkg::result_t chain_step_predict(input ssc_pkg::item_t w);
        ssc_pkg::result_t r;
        int               disp;
        int               bitn;
        int               idx;
        ssc_pkg::seg_t    val;
        r = '0;
        if (w.action == ssc_pkg::ACT_TICK)
        begin
            if (shift_active)
            begin
                if (bits_sent < ssc_pkg::TOTAL_BITS)
                begin
                    // last display first, LSB first
                    disp = ssc_pkg::NUM_DISPLAYS - 1 - bits_sent / ssc_pkg::BITS_PER_DISPLAY;
                    bitn = bits_sent % ssc_pkg::BITS_PER_DISPLAY;
                    r.serial_data = disp_bytes[disp][bitn];
                    r.shift_pulse = 1'b1;
                    bits_sent++;
                end
                else
                begin
                    r.latch_pulse = 1'b1;
                    shift_active  = 1'b0;
                    bits_sent     = 0;
                end
            end
        end
        else if (shift_active)
        begin
            r.refused = 1'b1;
        end
        else if (w.action == ssc_pkg::ACT_FLUSH)
        begin
            shift_active = 1'b1;
            bits_sent    = 0;
        end
        else if (int'(w.group) < ssc_pkg::GROUPS && int'(w.subposition) < ssc_pkg::SUBPOSITIONS)
        begin
            idx = int'(w.group) * ssc_pkg::SUBPOSITIONS + int'(w.subposition);
            val = '0;
            if (w.action == ssc_pkg::ACT_SET)
            begin
                val    = DIGIT_SEGS[int'(w.digit) * 8 +: 8];
                val[0] = val[0] | w.dot;
            end
            disp_bytes[idx] = val;
        end
        r.busy_res = shift_active;
        return r;
    endfunction

    task automatic check_field(input string field, input logic want, input logic got);
        if (got !== want)
        begin
            $error("%s: expected %0b, actual %0b", field, want, got);
            mismatches++;
        end
    endtask

    // Record accepted input words, then match accepted result words in order
    always @(posedge clk)
    begin
        ssc_pkg::result_t want;
        if (!rst_n)
        begin
            foreach (disp_bytes[i]) disp_bytes[i] = '0;
            bits_sent    = 0;
            shift_active = 1'b0;
            chain_results_due.delete();
        end
        else
        begin
            if (item_valid && !item_stall)
                chain_results_due.push_back(chain_step_predict(item));
            if (result_valid && !result_stall)
            begin
                if (chain_results_due.size() == 0)
                begin
                    $error("result word %b arrived with nothing expected", result);
                    mismatches++;
                end
                else
                begin
                    want = chain_results_due.pop_front();
                    check_field("serial_data", want.serial_data, result.serial_data);
                    check_field("shift_pulse", want.shift_pulse, result.shift_pulse);
                    check_field("latch_pulse", want.latch_pulse, result.latch_pulse);
                    check_field("busy_res", want.busy_res, result.busy_res);
                    check_field("refused", want.refused, result.refused);
                end
            end
        end
        results_due <= chain_results_due.size();
        fail_count  <= mismatches;
    end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top for the seven-segment chain driver: clock, reset, stimulus and verdict
module tb_top;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_WORDS  = 450;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;

    logic             clk;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    ssc_pkg::item_t   item         = '0;
    logic             result_stall = 1'b0;
    logic             item_stall;
    logic             result_valid;
    ssc_pkg::result_t result;
    int               fail_count;
    int               results_due;

    // Stimulus knobs and bookkeeping
    int idle_pct      = 0;
    int stall_pct     = 0;
    int hold_request  = 0;
    int shift_left    = 0;  // ticks still owed to a running shift-out
    int words_sent    = 0;
    int cycle_count   = 0;

    seven_segment_chain_driver u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    ssc_chain_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .fail_count   (fail_count),
        .results_due  (results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off on request
    int hold_seen = 0;
    int hold_left = 0;
    always @(posedge clk)
    begin
        if (hold_request != hold_seen)
        begin
            hold_seen    <= hold_request;
            hold_left    <= HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic ssc_pkg::item_t mk_word(input logic [1:0] act, input int g,
                                               input int s, input int d, input int dp);
        ssc_pkg::item_t w;
        w.action      = act;
        w.group       = g[1:0];
        w.subposition = s[1:0];
        w.digit       = d[3:0];
        w.dot         = dp[0];
        return w;
    endfunction

    // Mostly well-formed frames: writes, a flush, then ticks with stray refused words
    function automatic ssc_pkg::item_t random_word();
        ssc_pkg::item_t w;
        int             r;
        w.group       = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
        w.subposition = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
        w.digit       = ($urandom_range(7) == 0) ? 4'($urandom_range(15, 10))
                                                 : 4'($urandom_range(9));
        w.dot         = 1'($urandom_range(1));
        r = $urandom_range(99);
        if (shift_left > 0)
            w.action = (r < 88) ? ssc_pkg::ACT_TICK : 2'($urandom_range(2));
        else if (r < 8)
            w.action = ssc_pkg::ACT_TICK;
        else if (r < 22)
            w.action = ssc_pkg::ACT_FLUSH;
        else
            w.action = (r < 80) ? ssc_pkg::ACT_SET : ssc_pkg::ACT_BLANK;
        return w;
    endfunction

    // Offer one word, with random idle cycles before it, and wait until it is taken
    task automatic send_word(input ssc_pkg::item_t w);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        words_sent++;
        // follow a running shift-out so the random mix stays mostly ticks during it
        if (w.action == ssc_pkg::ACT_TICK)
        begin
            if (shift_left > 0)
            begin
                shift_left--;
            end
        end
        else if (shift_left == 0 && w.action == ssc_pkg::ACT_FLUSH)
        begin
            shift_left = ssc_pkg::TOTAL_BITS + 1;
        end
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        bit hold_done;
        bit pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle tick, field extremes, dark digits, out of range, refusals
        send_word(mk_word(ssc_pkg::ACT_TICK, 3, 3, 15, 1));
        send_word(mk_word(ssc_pkg::ACT_SET, 0, 0, 0, 0));
        send_word(mk_word(ssc_pkg::ACT_SET, 2, 2, 9, 1));
        send_word(mk_word(ssc_pkg::ACT_SET, 1, 1, 15, 1));
        send_word(mk_word(ssc_pkg::ACT_SET, 0, 1, 10, 0));
        send_word(mk_word(ssc_pkg::ACT_SET, 1, 0, 8, 1));
        send_word(mk_word(ssc_pkg::ACT_BLANK, 0, 1, 7, 1));
        send_word(mk_word(ssc_pkg::ACT_SET, 3, 0, 5, 1));
        send_word(mk_word(ssc_pkg::ACT_SET, 0, 3, 5, 1));
        send_word(mk_word(ssc_pkg::ACT_BLANK, 3, 3, 0, 0));
        send_word(mk_word(ssc_pkg::ACT_SET, 2, 0, 7, 0));
        send_word(mk_word(ssc_pkg::ACT_SET, 1, 2, 4, 1));
        send_word(mk_word(ssc_pkg::ACT_SET, 2, 1, 6, 1));
        send_word(mk_word(ssc_pkg::ACT_FLUSH, 0, 0, 0, 0));
        send_word(mk_word(ssc_pkg::ACT_SET, 2, 1, 3, 1));
        send_word(mk_word(ssc_pkg::ACT_BLANK, 2, 2, 0, 0));
        send_word(mk_word(ssc_pkg::ACT_FLUSH, 1, 1, 1, 1));
        send_word(mk_word(ssc_pkg::ACT_TICK, 0, 0, 0, 0));
        send_word(mk_word(ssc_pkg::ACT_TICK, 3, 3, 15, 1));

        // Random phases: no idling, sender idle, receiver stalling, both
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 69;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 69;
                end
                default:
                begin
                    idle_pct  = 35;
                    stall_pct = 35;
                end
            endcase
            while (words_sent < (phase + 1) * PHASE_WORDS)
            begin
                send_word(random_word());
                // long receiver hold-off while words keep coming
                if (!hold_done && words_sent >= 100)
                begin
                    hold_done = 1'b1;
                    hold_request++;
                end
                // sender pause until everything is back
                if (!pause_done && words_sent >= 250)
                begin
                    pause_done = 1'b1;
                    wait_drained();
                end
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
